FILE: src/assert_macros.svh
// assertion macros used by the checker file
// the enclosing module supplies clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define SSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define SSF_ASSERT_NEVER(label, expr, msg) \
    `SSF_ASSERT(label, !(expr), msg)

`endif

FILE: src/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// widths, reset values and register indexes of the sphere sub-voxel block
// ----------------------------------------------------------------------------
package ssf_pkg;

    // field widths
    parameter int COORD_W    = 32;
    parameter int RADIUS_W   = 63;
    parameter int CELL_W     = 31;
    parameter int COUNT_W    = 7;
    parameter int COUNT_MAX  = (1 << COUNT_W) - 1;

    // width of the low operand slice in the squarer
    parameter int MUL_W      = 32;

    // configuration port
    parameter int CFG_IDX_W  = 3;
    parameter int CFG_DATA_W = RADIUS_W;

    parameter logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    parameter logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    parameter logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd2;
    parameter logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd3;
    parameter logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 3'd4;
    parameter logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd5;
    parameter logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 3'd6;

    // one cell unit in unsigned Q7.24
    parameter logic [CELL_W-1:0] CELL_SIZE_RESET = 31'd16777216;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COUNT_W-1:0]        count_t;

endpackage

FILE: src/ssf_channels_if.sv
// ----------------------------------------------------------------------------
// ssf channel interfaces
// valid/ready channels for configuration writes, cell requests and results
// ----------------------------------------------------------------------------
interface ssf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ssf_pkg::CFG_IDX_W-1:0]    index;
    logic [ssf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ssf_coord_if;
    logic            valid;
    logic            ready;
    ssf_pkg::coord_t cell_x;
    ssf_pkg::coord_t cell_y;
    ssf_pkg::coord_t cell_z;

    modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

interface ssf_frac_if;
    logic            valid;
    logic            ready;
    ssf_pkg::count_t hit_count;
    logic            any_inside;

    modport source (output valid, output hit_count, output any_inside, input ready);
    modport sink   (input valid, input hit_count, input any_inside, output ready);
endinterface

FILE: src/sphere_subvoxel_fraction.sv
// ----------------------------------------------------------------------------
// sphere_subvoxel_fraction
// counts the sub-samples of one cell that lie strictly inside a sphere
// ----------------------------------------------------------------------------
// cfg   : register writes (index, data), always ready; write only while idle
// coord : one request per cell centre (cell_x, cell_y, cell_z in Q8.24)
// frac  : one result per request (hit_count, any_inside)
// a request is taken only while the sequencer is idle. the 3*N sample offsets
// (N = SUBSAMPLES_PER_AXIS) go through the shared squarer one per cycle into
// small per-axis tables, then x^2 + y^2 + z^2 of one of the N^3 samples is
// summed per cycle and compared with the scaled radius
// per request the sequencer steps through prep, setup, sum, drain and finish;
// a new request is taken only after the previous result has entered the
// output register
// rst_n clears the sequencer and output valid; registers return to a centre
// of zero, a radius of zero and unit cell sizes
// a stalled result sits in the output register while the next request is
// taken and worked on; only the hand-off into the output register waits
// ----------------------------------------------------------------------------
module sphere_subvoxel_fraction #(
    parameter int SUBSAMPLES_PER_AXIS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ssf_cfg_if.sink     cfg,
    ssf_coord_if.sink   coord,
    ssf_frac_if.source  frac
);

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int N       = SUBSAMPLES_PER_AXIS;
    localparam int TWO_N   = 2 * N;
    localparam int OFF_N   = N - 1;
    localparam int FOUR_NN = 4 * N * N;
    localparam int SCALE_W = $clog2(TWO_N);
    localparam int IDX_W   = $clog2(N);
    localparam int DIFF_W  = ssf_pkg::COORD_W + 1;
    // offset from sphere centre, scaled by 2N
    localparam int R_W     = DIFF_W + 1 + SCALE_W;
    localparam int MAG_W   = R_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    // sum of three squares
    localparam int SUM_W   = SQ_W + 2;
    localparam int CNT_W   = $clog2(N * N * N + 1);
    localparam int CW      = ssf_pkg::COUNT_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [ssf_pkg::COORD_W-1:0]  center_x_reg;
    logic signed [ssf_pkg::COORD_W-1:0]  center_y_reg;
    logic signed [ssf_pkg::COORD_W-1:0]  center_z_reg;
    logic        [ssf_pkg::RADIUS_W-1:0] radius_sq_reg;
    logic        [ssf_pkg::CELL_W-1:0]   cell_size_x_reg;
    logic        [ssf_pkg::CELL_W-1:0]   cell_size_y_reg;
    logic        [ssf_pkg::CELL_W-1:0]   cell_size_z_reg;

    assign cfg.ready = 1'b1;

    // unknown indexes fall through and are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            radius_sq_reg   <= '0;
            cell_size_x_reg <= ssf_pkg::CELL_SIZE_RESET;
            cell_size_y_reg <= ssf_pkg::CELL_SIZE_RESET;
            cell_size_z_reg <= ssf_pkg::CELL_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ssf_pkg::REG_CENTER_X:    center_x_reg    <= $signed(cfg.data[ssf_pkg::COORD_W-1:0]);
                ssf_pkg::REG_CENTER_Y:    center_y_reg    <= $signed(cfg.data[ssf_pkg::COORD_W-1:0]);
                ssf_pkg::REG_CENTER_Z:    center_z_reg    <= $signed(cfg.data[ssf_pkg::COORD_W-1:0]);
                ssf_pkg::REG_RADIUS_SQ:   radius_sq_reg   <= cfg.data[ssf_pkg::RADIUS_W-1:0];
                ssf_pkg::REG_CELL_SIZE_X: cell_size_x_reg <= cfg.data[ssf_pkg::CELL_W-1:0];
                ssf_pkg::REG_CELL_SIZE_Y: cell_size_y_reg <= cfg.data[ssf_pkg::CELL_W-1:0];
                ssf_pkg::REG_CELL_SIZE_Z: cell_size_z_reg <= cfg.data[ssf_pkg::CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [2:0]       state_reg,     state_next;
    logic [1:0]       prep_axis_reg, prep_axis_next;
    logic [IDX_W-1:0] prep_idx_reg,  prep_idx_next;
    logic             sq_pend_reg,   sq_pend_next;
    logic [IDX_W-1:0] sx_reg,        sx_next;
    logic [IDX_W-1:0] sy_reg,        sy_next;
    logic [IDX_W-1:0] sz_reg,        sz_next;
    logic             tot_valid_reg, tot_valid_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] diff_x_reg;
    logic signed [DIFF_W-1:0] diff_y_reg;
    logic signed [DIFF_W-1:0] diff_z_reg;
    logic        [SUM_W-1:0]  thr_reg;
    logic signed [R_W-1:0]    r_reg;
    logic        [1:0]        sq_axis_reg;
    logic        [IDX_W-1:0]  sq_idx_reg;
    logic        [SQ_W-1:0]   sqx_reg [N];
    logic        [SQ_W-1:0]   sqy_reg [N];
    logic        [SQ_W-1:0]   sqz_reg [N];
    logic        [SUM_W-1:0]  yz_reg;
    logic        [SUM_W-1:0]  yz_ahead_reg;
    logic        [SUM_W-1:0]  tot_reg;
    logic        [CW-1:0]     out_count_reg;
    logic                     out_any_reg;

    logic in_take;
    logic out_load;

    assign coord.ready = (state_reg == ST_IDLE);
    assign in_take     = coord.valid && coord.ready;
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || frac.ready);

    assign frac.valid      = out_valid_reg;
    assign frac.hit_count  = out_count_reg;
    assign frac.any_inside = out_any_reg;

    // ------------------------------------------------------------------
    // offset of one sample along one axis: start value, then +2*cell
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]         diff_sel;
    logic        [ssf_pkg::CELL_W-1:0] cell_sel;
    logic signed [R_W-1:0]            diff_ext;
    logic signed [R_W-1:0]            scaled;
    logic signed [R_W-1:0]            offset;
    logic signed [R_W-1:0]            step;
    logic signed [R_W-1:0]            r_new;

    always_comb
    begin
        case (prep_axis_reg)
            AX_X:
            begin
                diff_sel = diff_x_reg;
                cell_sel = cell_size_x_reg;
            end
            AX_Y:
            begin
                diff_sel = diff_y_reg;
                cell_sel = cell_size_y_reg;
            end
            default:
            begin
                diff_sel = diff_z_reg;
                cell_sel = cell_size_z_reg;
            end
        endcase
    end

    assign diff_ext = R_W'(diff_sel);
    assign scaled   = diff_ext * $signed(R_W'(TWO_N));
    assign offset   = $signed(R_W'(cell_sel) * R_W'(OFF_N));
    assign step     = $signed(R_W'({cell_sel, 1'b0}));
    assign r_new    = (prep_idx_reg == '0) ? (scaled - offset) : (r_reg + step);

    // shared squarer on the magnitude of the current offset
    logic [MAG_W-1:0] r_mag;
    logic [SQ_W-1:0]  r_sq;

    assign r_mag = r_reg[R_W-1] ? MAG_W'(-r_reg) : MAG_W'(r_reg);

    ssf_square #(
        .MAG_W (MAG_W)
    ) u_square (
        .mag (r_mag),
        .sq  (r_sq)
    );

    // ------------------------------------------------------------------
    // y^2 + z^2 for the row that follows (or the first row in setup)
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] rd_y;
    logic [IDX_W-1:0] rd_z;
    logic [SUM_W-1:0] yz_sum;
    logic [SUM_W-1:0] tot_sum;

    always_comb
    begin
        if (state_reg == ST_SETUP)
        begin
            rd_y = '0;
            rd_z = '0;
        end
        else if (sy_reg == LAST_IDX)
        begin
            rd_y = '0;
            rd_z = (sz_reg == LAST_IDX) ? '0 : sz_reg + 1'b1;
        end
        else
        begin
            rd_y = sy_reg + 1'b1;
            rd_z = sz_reg;
        end
    end

    assign yz_sum  = SUM_W'(sqy_reg[rd_y]) + SUM_W'(sqz_reg[rd_z]);
    assign tot_sum = SUM_W'(sqx_reg[sx_reg]) + yz_reg;

    // result saturates to the output width
    logic [CW-1:0] count_sat;

    assign count_sat = (int'(count_reg) > ssf_pkg::COUNT_MAX) ?
                       CW'(ssf_pkg::COUNT_MAX) : CW'(count_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        prep_axis_next = prep_axis_reg;
        prep_idx_next  = prep_idx_reg;
        sq_pend_next   = 1'b0;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sz_next        = sz_reg;
        tot_valid_next = 1'b0;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && frac.ready)
        begin
            out_valid_next = 1'b0;
        end

        // compare stage works on the sum registered by the sum stage
        if (tot_valid_reg && (tot_reg < thr_reg))
        begin
            count_next = count_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (coord.valid)
                begin
                    state_next     = ST_PREP;
                    prep_axis_next = AX_X;
                    prep_idx_next  = '0;
                    count_next     = '0;
                end
            end
            ST_PREP:
            begin
                sq_pend_next = 1'b1;
                if (prep_idx_reg == LAST_IDX)
                begin
                    prep_idx_next = '0;
                    if (prep_axis_reg == AX_Z)
                    begin
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        prep_axis_next = prep_axis_reg + 1'b1;
                    end
                end
                else
                begin
                    prep_idx_next = prep_idx_reg + 1'b1;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SUM;
                sx_next    = '0;
                sy_next    = '0;
                sz_next    = '0;
            end
            ST_SUM:
            begin
                tot_valid_next = 1'b1;
                if (sx_reg == LAST_IDX)
                begin
                    sx_next = '0;
                    if (sy_reg == LAST_IDX)
                    begin
                        sy_next = '0;
                        if (sz_reg == LAST_IDX)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            sz_next = sz_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sy_next = sy_reg + 1'b1;
                    end
                end
                else
                begin
                    sx_next = sx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || frac.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prep_axis_reg <= AX_X;
            prep_idx_reg  <= '0;
            sq_pend_reg   <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            tot_valid_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prep_axis_reg <= prep_axis_next;
            prep_idx_reg  <= prep_idx_next;
            sq_pend_reg   <= sq_pend_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sz_reg        <= sz_next;
            tot_valid_reg <= tot_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // differences at 33 bits, threshold (2N)^2 * r^2 at full width
        if (in_take)
        begin
            diff_x_reg <= DIFF_W'(coord.cell_x) - DIFF_W'(center_x_reg);
            diff_y_reg <= DIFF_W'(coord.cell_y) - DIFF_W'(center_y_reg);
            diff_z_reg <= DIFF_W'(coord.cell_z) - DIFF_W'(center_z_reg);
            thr_reg    <= SUM_W'(radius_sq_reg) * SUM_W'(FOUR_NN);
        end

        if (state_reg == ST_PREP)
        begin
            r_reg       <= r_new;
            sq_axis_reg <= prep_axis_reg;
            sq_idx_reg  <= prep_idx_reg;
        end

        // square lands in its table in the cycle after the offset is registered
        if (sq_pend_reg)
        begin
            case (sq_axis_reg)
                AX_X:    sqx_reg[sq_idx_reg] <= r_sq;
                AX_Y:    sqy_reg[sq_idx_reg] <= r_sq;
                default: sqz_reg[sq_idx_reg] <= r_sq;
            endcase
        end

        if (state_reg == ST_SETUP)
        begin
            yz_reg <= yz_sum;
        end

        if (state_reg == ST_SUM)
        begin
            tot_reg <= tot_sum;
            if (sx_reg == '0)
            begin
                yz_ahead_reg <= yz_sum;
            end
            if (sx_reg == LAST_IDX)
            begin
                yz_reg <= yz_ahead_reg;
            end
        end

        if (out_load)
        begin
            out_count_reg <= count_sat;
            out_any_reg   <= (count_reg != '0);
        end
    end

endmodule

FILE: src/ssf_square.sv
// ----------------------------------------------------------------------------
// ssf_square
// unsigned squarer built from one 32x32 partial product and two narrow ones
// ----------------------------------------------------------------------------
module ssf_square #(
    parameter int MAG_W = 37
) (
    input  logic [MAG_W-1:0]   mag,
    output logic [2*MAG_W-1:0] sq
);

    localparam int LO_W = ssf_pkg::MUL_W;
    localparam int HI_W = MAG_W - LO_W;
    localparam int SQ_W = 2 * MAG_W;

    logic [LO_W-1:0]        lo;
    logic [HI_W-1:0]        hi;
    logic [2*LO_W-1:0]      prod_ll;
    logic [HI_W+LO_W-1:0]   prod_hl;
    logic [2*HI_W-1:0]      prod_hh;

    assign lo = mag[LO_W-1:0];
    assign hi = mag[MAG_W-1:LO_W];

    assign prod_ll = lo * lo;
    assign prod_hl = hi * lo;
    assign prod_hh = hi * hi;

    // (h*2^32 + l)^2 = l^2 + 2*h*l*2^32 + h^2*2^64
    assign sq = SQ_W'(prod_ll)
              + (SQ_W'(prod_hl) << (LO_W + 1))
              + (SQ_W'(prod_hh) << (2 * LO_W));

endmodule

FILE: src/ssf_checker.sv
// ----------------------------------------------------------------------------
// ssf_checker
// port-level assertions for sphere_subvoxel_fraction, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssf_checker #(
    parameter int SUBSAMPLES_PER_AXIS = 4
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ssf_pkg::COUNT_W-1:0]  hit_count,
    input logic                         any_inside
);

    localparam int CUBE = SUBSAMPLES_PER_AXIS * SUBSAMPLES_PER_AXIS * SUBSAMPLES_PER_AXIS;
    localparam int LIMIT = (CUBE > ssf_pkg::COUNT_MAX) ? ssf_pkg::COUNT_MAX : CUBE;
    localparam logic [ssf_pkg::COUNT_W-1:0] COUNT_LIMIT = ssf_pkg::COUNT_W'(LIMIT);

    logic                      out_stall;
    logic [ssf_pkg::COUNT_W:0] result_bits;

    assign out_stall   = out_valid && !out_ready;
    assign result_bits = {hit_count, any_inside};

    // stalled result holds
    `SSF_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(result_bits), "stalled result changed")

    // flag agrees with the count
    `SSF_ASSERT(a_flag_match, out_valid |-> (any_inside == (hit_count != '0)), "flag mismatch")

    // never more samples than the grid holds
    `SSF_ASSERT_NEVER(a_count_bound, out_valid && (hit_count > COUNT_LIMIT), "count above grid")

    // one request at a time
    `SSF_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "request taken while busy")

endmodule

bind sphere_subvoxel_fraction ssf_checker #(
    .SUBSAMPLES_PER_AXIS (SUBSAMPLES_PER_AXIS)
) u_ssf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (coord.valid),
    .in_ready   (coord.ready),
    .out_valid  (frac.valid),
    .out_ready  (frac.ready),
    .hit_count  (frac.hit_count),
    .any_inside (frac.any_inside)
);

FILE: bench/tb_sphere_subvoxel_fraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_subvoxel_fraction
// self-checking bench for the sphere sub-voxel fraction counter: a directed
// table of extremes and boundary cases, then randomized register settings
// with cells placed mostly around the sphere surface, each result compared
// against a fixed expected value or an exact wide-integer recount of the N x N x N sub-samples
// ----------------------------------------------------------------------------
module tb_sphere_subvoxel_fraction;

    // block geometry, matches the instance below
    localparam int N           = 4;
    localparam int TWO_N       = 2 * N;
    localparam int LATENCY     = N * N * N + 3 * N + 3;

    // run shape
    localparam int RANDOM_PHASES   = 12;
    localparam int CELLS_PER_PHASE = 90;
    localparam int MAX_WAIT        = 17;
    localparam int SQUEEZE_CYCLES  = 600;
    localparam int CYCLE_LIMIT     = 1000000;

    // register index the block does not decode
    localparam logic [ssf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // handy values
    localparam ssf_pkg::coord_t C_MIN  = 32'sh8000_0000;
    localparam ssf_pkg::coord_t C_MAX  = 32'sh7FFF_FFFF;
    localparam ssf_pkg::coord_t C_ONE  = 32'sh0100_0000;
    localparam ssf_pkg::coord_t C_HALF = 32'sh0080_0000;
    localparam logic [ssf_pkg::CELL_W-1:0]   CELL_MAX = 31'h7FFF_FFFF;
    localparam logic [ssf_pkg::RADIUS_W-1:0] RAD_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        ssf_pkg::count_t hit_count;
        logic            any_inside;
    } frac_t;

    // one row of the directed table: either a register write or a cell request
    typedef struct {
        logic                           is_write;
        logic [ssf_pkg::CFG_IDX_W-1:0]  idx;
        logic [ssf_pkg::CFG_DATA_W-1:0] data;
        ssf_pkg::coord_t                x;
        ssf_pkg::coord_t                y;
        ssf_pkg::coord_t                z;
        logic                           typed;
        frac_t                          want;
    } step_t;

    logic clk;
    logic rst_n;

    ssf_cfg_if   cfg_bus ();
    ssf_coord_if coord_bus ();
    ssf_frac_if  frac_bus ();

    sphere_subvoxel_fraction #(
        .SUBSAMPLES_PER_AXIS (N)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .coord (coord_bus),
        .frac  (frac_bus)
    );

    // mirror of the block's registers, updated on each accepted write
    ssf_pkg::coord_t              cen_x;
    ssf_pkg::coord_t              cen_y;
    ssf_pkg::coord_t              cen_z;
    logic [ssf_pkg::RADIUS_W-1:0] rad_sq;
    logic [ssf_pkg::CELL_W-1:0]   size_x;
    logic [ssf_pkg::CELL_W-1:0]   size_y;
    logic [ssf_pkg::CELL_W-1:0]   size_z;

    // fractions still owed by the block, oldest first
    frac_t pending_fractions[$];

    int mismatches;
    int cells_sent;
    int results_seen;
    int cells_left_in_phase;
    int cycles;
    bit squeezed;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // exact recount
    // ------------------------------------------------------------------------

    // square of the magnitude, kept at full width so nothing overflows
    function automatic logic [127:0] square_mag(longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return 128'(m) * 128'(m);
    endfunction

    // every offset is scaled by 2N so that sample positions stay integral;
    // the squared radius is scaled by (2N)^2 to match
    function automatic frac_t count_inside_samples(ssf_pkg::coord_t x,
                                                   ssf_pkg::coord_t y,
                                                   ssf_pkg::coord_t z);
        longint         bx;
        longint         by;
        longint         bz;
        longint         rx;
        longint         ry;
        longint         rz;
        logic [127:0]   limit;
        logic [127:0]   sq_dist;
        int             hits;
        frac_t          r;
        bx = (longint'(x) - longint'(cen_x)) * TWO_N;
        by = (longint'(y) - longint'(cen_y)) * TWO_N;
        bz = (longint'(z) - longint'(cen_z)) * TWO_N;
        limit = 128'(rad_sq) * 128'(TWO_N * TWO_N);
        hits = 0;
        for (int sz = 0; sz < N; sz++)
        begin
            rz = bz + longint'(2 * sz + 1 - N) * longint'(size_z);
            for (int sy = 0; sy < N; sy++)
            begin
                ry = by + longint'(2 * sy + 1 - N) * longint'(size_y);
                for (int sx = 0; sx < N; sx++)
                begin
                    rx = bx + longint'(2 * sx + 1 - N) * longint'(size_x);
                    sq_dist = square_mag(rx) + square_mag(ry) + square_mag(rz);
                    // strictly inside only, a sample on the surface is out
                    if (sq_dist < limit)
                        hits++;
                end
            end
        end
        r.hit_count  = (hits > ssf_pkg::COUNT_MAX) ?
                       ssf_pkg::count_t'(ssf_pkg::COUNT_MAX) : ssf_pkg::count_t'(hits);
        r.any_inside = (hits != 0);
        return r;
    endfunction

    // unknown indexes fall through and change nothing
    function automatic void note_register(logic [ssf_pkg::CFG_IDX_W-1:0] idx,
                                          logic [ssf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ssf_pkg::REG_CENTER_X:    cen_x  = data[ssf_pkg::COORD_W-1:0];
            ssf_pkg::REG_CENTER_Y:    cen_y  = data[ssf_pkg::COORD_W-1:0];
            ssf_pkg::REG_CENTER_Z:    cen_z  = data[ssf_pkg::COORD_W-1:0];
            ssf_pkg::REG_RADIUS_SQ:   rad_sq = data[ssf_pkg::RADIUS_W-1:0];
            ssf_pkg::REG_CELL_SIZE_X: size_x = data[ssf_pkg::CELL_W-1:0];
            ssf_pkg::REG_CELL_SIZE_Y: size_y = data[ssf_pkg::CELL_W-1:0];
            ssf_pkg::REG_CELL_SIZE_Z: size_z = data[ssf_pkg::CELL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] wide_random();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------------
    function automatic step_t write_step(logic [ssf_pkg::CFG_IDX_W-1:0] idx,
                                         logic [ssf_pkg::CFG_DATA_W-1:0] data);
        step_t s;
        s = '{default: '0};
        s.is_write = 1'b1;
        s.idx      = idx;
        s.data     = data;
        return s;
    endfunction

    function automatic step_t cell_step(ssf_pkg::coord_t x, ssf_pkg::coord_t y,
                                        ssf_pkg::coord_t z);
        step_t s;
        s = '{default: '0};
        s.x = x;
        s.y = y;
        s.z = z;
        return s;
    endfunction

    // request whose result is obvious without a recount
    function automatic step_t known_step(ssf_pkg::coord_t x, ssf_pkg::coord_t y,
                                         ssf_pkg::coord_t z,
                                         ssf_pkg::count_t n, logic hit);
        step_t s;
        s = cell_step(x, y, z);
        s.typed           = 1'b1;
        s.want.hit_count  = n;
        s.want.any_inside = hit;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // any request implies the write channel is done, so its valid drops here
    task automatic send_cell(ssf_pkg::coord_t x, ssf_pkg::coord_t y, ssf_pkg::coord_t z,
                             logic typed, frac_t want);
        int gap;
        cfg_bus.valid <= 1'b0;
        // runs of back-to-back requests, otherwise a random gap
        gap = (cells_sent % 100 < 30) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            coord_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coord_bus.valid  <= 1'b1;
        coord_bus.cell_x <= x;
        coord_bus.cell_y <= y;
        coord_bus.cell_z <= z;
        do
            @(posedge clk);
        while (!coord_bus.ready);
        pending_fractions.push_back(typed ? want : count_inside_samples(x, y, z));
        cells_sent++;
    endtask

    // registers only change with nothing in flight
    task automatic quiesce();
        coord_bus.valid <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [ssf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ssf_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        note_register(idx, data);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off, field-by-field compare
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int    stall;
        frac_t want;
        frac_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // hold off long enough for the block to fill and refuse requests,
            // only while the request side still has plenty to offer
            if (!squeezed && results_seen >= 300 && cells_left_in_phase > 20)
            begin
                stall    = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            else if (results_seen % 128 < 40)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                frac_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frac_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!frac_bus.valid);
            results_seen++;
            if (pending_fractions.size() == 0)
            begin
                $display("%0t: unexpected result, hit_count %0d any_inside %0b",
                         $time, frac_bus.hit_count, frac_bus.any_inside);
                mismatches++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (frac_bus.hit_count !== want.hit_count)
                begin
                    $display("%0t: hit_count expected %0d actual %0d",
                             $time, want.hit_count, frac_bus.hit_count);
                    mismatches++;
                end
                if (frac_bus.any_inside !== want.any_inside)
                begin
                    $display("%0t: any_inside expected %0b actual %0b",
                             $time, want.any_inside, frac_bus.any_inside);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        step_t                        directed[$];
        ssf_pkg::coord_t              ctr[3];
        logic [ssf_pkg::CELL_W-1:0]   csize[3];
        logic [ssf_pkg::RADIUS_W-1:0] rsq;
        longint                       reach;
        longint                       widest;
        longint                       span;
        longint                       off;
        ssf_pkg::coord_t              pos[3];
        int                           kind;
        int                           pick;

        // every input known from the first instant
        rst_n            <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= ssf_pkg::REG_CENTER_X;
        cfg_bus.data     <= '0;
        coord_bus.valid  <= 1'b0;
        coord_bus.cell_x <= '0;
        coord_bus.cell_y <= '0;
        coord_bus.cell_z <= '0;
        mismatches          = 0;
        cells_sent          = 0;
        results_seen        = 0;
        cells_left_in_phase = 0;
        squeezed            = 1'b0;

        // reset values of the register mirror
        cen_x  = '0;
        cen_y  = '0;
        cen_z  = '0;
        rad_sq = '0;
        size_x = ssf_pkg::CELL_SIZE_RESET;
        size_y = ssf_pkg::CELL_SIZE_RESET;
        size_z = ssf_pkg::CELL_SIZE_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // -- directed table --------------------------------------------------
        // zero radius after reset: nothing can be inside
        directed.push_back(known_step('0, '0, '0, '0, 1'b0));
        directed.push_back(known_step(C_MAX, C_MAX, C_MAX, '0, 1'b0));
        directed.push_back(known_step(C_MIN, C_MIN, C_MIN, '0, 1'b0));
        // largest radius: the home cell is fully inside
        directed.push_back(write_step(ssf_pkg::REG_RADIUS_SQ, RAD_MAX));
        directed.push_back(known_step('0, '0, '0, 7'd64, 1'b1));
        directed.push_back(cell_step(C_MAX, C_MIN, C_MAX));
        directed.push_back(cell_step(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F));
        // centre at the coordinate corners with widest cells: differences
        // need the 33rd bit and squared sums run past 64 bits
        directed.push_back(write_step(ssf_pkg::REG_CENTER_X, 63'(C_MIN)));
        directed.push_back(write_step(ssf_pkg::REG_CENTER_Y, {31'h7FFF_FFFF, C_MAX}));
        directed.push_back(write_step(ssf_pkg::REG_CENTER_Z, 63'(C_MIN)));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_X, 63'(CELL_MAX)));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Y, 63'(CELL_MAX)));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Z, {32'hFFFF_FFFF, CELL_MAX}));
        directed.push_back(cell_step(C_MAX, C_MIN, C_MAX));
        directed.push_back(cell_step(C_MIN, C_MAX, C_MIN));
        directed.push_back(cell_step(C_MAX, C_MAX, C_MAX));
        // zero cell size collapses all samples onto the centre; smallest
        // radius then separates inside from exactly-on-the-surface
        directed.push_back(write_step(ssf_pkg::REG_CENTER_X, '0));
        directed.push_back(write_step(ssf_pkg::REG_CENTER_Y, '0));
        directed.push_back(write_step(ssf_pkg::REG_CENTER_Z, '0));
        directed.push_back(write_step(ssf_pkg::REG_RADIUS_SQ, 63'd1));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_X, '0));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Y, '0));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Z, '0));
        directed.push_back(known_step('0, '0, '0, 7'd64, 1'b1));
        directed.push_back(known_step(32'sd1, '0, '0, '0, 1'b0));
        directed.push_back(known_step('0, '0, -32'sd1, '0, 1'b0));
        // write to an undecoded index leaves everything as it was
        directed.push_back(write_step(REG_UNUSED, RAD_MAX));
        directed.push_back(known_step('0, '0, '0, 7'd64, 1'b1));
        // unit cells and unit radius: partial counts around the surface
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_X,
                                      63'(ssf_pkg::CELL_SIZE_RESET)));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Y,
                                      63'(ssf_pkg::CELL_SIZE_RESET)));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Z,
                                      63'(ssf_pkg::CELL_SIZE_RESET)));
        directed.push_back(write_step(ssf_pkg::REG_RADIUS_SQ, 63'd1 << 48));
        directed.push_back(cell_step('0, '0, '0));
        directed.push_back(cell_step(C_ONE, '0, '0));
        directed.push_back(cell_step(C_HALF, C_HALF, '0));
        // smallest non-zero cell size and unequal axes
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_X, 63'd1));
        directed.push_back(write_step(ssf_pkg::REG_CELL_SIZE_Z, 63'(C_ONE) << 1));
        directed.push_back(write_step(ssf_pkg::REG_RADIUS_SQ, 63'd9 << 46));
        directed.push_back(cell_step(C_ONE, -C_ONE, '0));
        directed.push_back(cell_step('0, C_HALF, -C_ONE));

        foreach (directed[i])
        begin
            if (directed[i].is_write)
            begin
                quiesce();
                write_register(directed[i].idx, directed[i].data);
            end
            else
                send_cell(directed[i].x, directed[i].y, directed[i].z,
                          directed[i].typed, directed[i].want);
        end

        // -- random phases ---------------------------------------------------
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiesce();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // corner settings
                for (int a = 0; a < 3; a++)
                begin
                    pick = $urandom_range(0, 4);
                    ctr[a] = (pick == 0) ? C_MIN : (pick == 1) ? C_MAX :
                             (pick == 2) ? ssf_pkg::coord_t'(0) :
                             (pick == 3) ? -32'sd1 : 32'sd1;
                    pick = $urandom_range(0, 3);
                    csize[a] = (pick == 0) ? '0 : (pick == 1) ? 31'd1 :
                               (pick == 2) ? CELL_MAX : ssf_pkg::CELL_SIZE_RESET;
                end
                pick = $urandom_range(0, 3);
                rsq = (pick == 0) ? '0 : (pick == 1) ? 63'd1 :
                      (pick == 2) ? RAD_MAX : 63'(wide_random());
                reach = 64'sd1 << 31;
            end
            else if (kind == 1)
            begin
                // anything goes
                for (int a = 0; a < 3; a++)
                begin
                    ctr[a]   = $urandom();
                    csize[a] = ssf_pkg::CELL_W'($urandom());
                end
                rsq   = 63'(wide_random());
                reach = 64'sd1 << 31;
            end
            else
            begin
                // sphere a few cells across, cells scattered around its surface
                widest = 0;
                for (int a = 0; a < 3; a++)
                begin
                    ctr[a]   = $urandom();
                    csize[a] = ssf_pkg::CELL_W'($urandom_range(1 << 18, 1 << 26));
                    if (longint'(csize[a]) > widest)
                        widest = longint'(csize[a]);
                end
                reach = widest * $urandom_range(0, 6) + longint'($urandom() % widest);
                rsq   = 63'(reach * reach);
            end

            // upper data bits beyond each register's width are junk
            write_register(ssf_pkg::REG_CENTER_X, {31'($urandom()), ctr[0]});
            write_register(ssf_pkg::REG_CENTER_Y, {31'($urandom()), ctr[1]});
            write_register(ssf_pkg::REG_CENTER_Z, {31'($urandom()), ctr[2]});
            write_register(ssf_pkg::REG_RADIUS_SQ, rsq);
            write_register(ssf_pkg::REG_CELL_SIZE_X, {32'($urandom()), csize[0]});
            write_register(ssf_pkg::REG_CELL_SIZE_Y, {32'($urandom()), csize[1]});
            write_register(ssf_pkg::REG_CELL_SIZE_Z, {32'($urandom()), csize[2]});
            if ($urandom_range(0, 2) == 0)
                write_register(REG_UNUSED, 63'(wide_random()));

            for (int k = 0; k < CELLS_PER_PHASE; k++)
            begin
                cells_left_in_phase = CELLS_PER_PHASE - k;
                if ($urandom_range(0, 99) < 85)
                begin
                    // within the sphere's reach plus a couple of cells
                    for (int a = 0; a < 3; a++)
                    begin
                        span   = reach + 2 * longint'(csize[a]);
                        off    = longint'(wide_random() % 64'(2 * span + 1)) - span;
                        pos[a] = ssf_pkg::coord_t'(longint'(ctr[a]) + off);
                    end
                end
                else
                begin
                    for (int a = 0; a < 3; a++)
                        pos[a] = $urandom();
                end
                send_cell(pos[0], pos[1], pos[2], 1'b0, '0);
            end
            cells_left_in_phase = 0;
        end

        // -- wind down -------------------------------------------------------
        quiesce();
        // catch any stray result
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
